// File: rtl/erpt_pkg.sv
// Package for the Euler rigid point transform: widths, CORDIC table, types.
// No dependencies.
`default_nettype none
package erpt_pkg;
  localparam int POS_W = 32;
  localparam int TAG_W = 16;
  localparam int CFG_W = 32;
  localparam int IDX_W = 3;
  localparam int COEF_W = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int DEF_POSITION_FRACTION_BITS = 16;
  localparam int DEF_ANGLE_WIDTH = 16;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [IDX_W-1:0] REG_ROLL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PITCH = 3'd1;
  localparam logic [IDX_W-1:0] REG_YAW   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SX    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SY    = 3'd4;
  localparam logic [IDX_W-1:0] REG_SZ    = 3'd5;

  typedef enum logic [2:0] {
    MB_IDLE, MB_ROLL, MB_PITCH, MB_YAW, MB_MUL1, MB_MUL2, MB_MUL3
  } mb_state_t;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: atan_turn = 34'sd536870912;  5'd1: atan_turn = 34'sd316933406;
      5'd2: atan_turn = 34'sd167458907;  5'd3: atan_turn = 34'sd85004756;
      5'd4: atan_turn = 34'sd42667331;   5'd5: atan_turn = 34'sd21354465;
      5'd6: atan_turn = 34'sd10679838;   5'd7: atan_turn = 34'sd5340245;
      5'd8: atan_turn = 34'sd2670163;    5'd9: atan_turn = 34'sd1335087;
      5'd10: atan_turn = 34'sd667544;    5'd11: atan_turn = 34'sd333772;
      5'd12: atan_turn = 34'sd166886;    5'd13: atan_turn = 34'sd83443;
      5'd14: atan_turn = 34'sd41722;     5'd15: atan_turn = 34'sd20861;
      5'd16: atan_turn = 34'sd10430;     5'd17: atan_turn = 34'sd5215;
      5'd18: atan_turn = 34'sd2608;      5'd19: atan_turn = 34'sd1304;
      5'd20: atan_turn = 34'sd652;       5'd21: atan_turn = 34'sd326;
      5'd22: atan_turn = 34'sd163;       5'd23: atan_turn = 34'sd81;
      5'd24: atan_turn = 34'sd41;        5'd25: atan_turn = 34'sd20;
      5'd26: atan_turn = 34'sd10;        5'd27: atan_turn = 34'sd5;
      default: atan_turn = 34'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/erpt_if.sv
// Valid/ready channel interfaces for point and result beats.
// Depends on erpt_pkg.
`default_nettype none
interface erpt_point_if;
  logic valid;
  logic ready;
  logic signed [erpt_pkg::POS_W-1:0] point_x;
  logic signed [erpt_pkg::POS_W-1:0] point_y;
  logic signed [erpt_pkg::POS_W-1:0] point_z;
  logic [erpt_pkg::TAG_W-1:0] landmark_tag;
  modport source (output valid, point_x, point_y, point_z, landmark_tag, input ready);
  modport sink (input valid, point_x, point_y, point_z, landmark_tag, output ready);
endinterface

interface erpt_moved_if;
  logic valid;
  logic ready;
  logic signed [erpt_pkg::POS_W-1:0] moved_x;
  logic signed [erpt_pkg::POS_W-1:0] moved_y;
  logic signed [erpt_pkg::POS_W-1:0] moved_z;
  logic [erpt_pkg::TAG_W-1:0] moved_tag;
  modport source (output valid, moved_x, moved_y, moved_z, moved_tag, input ready);
  modport sink (input valid, moved_x, moved_y, moved_z, moved_tag, output ready);
endinterface
`default_nettype wire

// File: rtl/erpt_matrix.sv
// Coefficient builder: one CORDIC step a cycle per angle, then the rotation
// products over a shared multiplier. Depends on erpt_pkg.
`default_nettype none
module erpt_matrix #(
  parameter int ANGLE_WIDTH = erpt_pkg::DEF_ANGLE_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [ANGLE_WIDTH-1:0] roll,
  input  wire logic signed [ANGLE_WIDTH-1:0] pitch,
  input  wire logic signed [ANGLE_WIDTH-1:0] yaw,
  output logic busy,
  output logic signed [erpt_pkg::COEF_W-1:0] coef [9]
);
  erpt_pkg::mb_state_t state, state_next;
  logic [4:0] step;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic signed [erpt_pkg::COEF_W-1:0] cr, sr, cp, sp, cw, sw;
  logic signed [erpt_pkg::COEF_W-1:0] tsp, tcp; // sr*sp, cr*sp
  logic [3:0] mstep;

  logic signed [ANGLE_WIDTH-1:0] ang;
  logic signed [31:0] u;
  logic signed [33:0] z0, dx, dy;
  logic z_neg;
  logic signed [33:0] x_fin, y_fin;

  always_comb begin
    case (state)
      erpt_pkg::MB_PITCH: ang = pitch;
      erpt_pkg::MB_YAW:   ang = yaw;
      default:            ang = roll;
    endcase
    u = {ang, {(32-ANGLE_WIDTH){1'b0}}};
    z0 = 34'(u);
    dx = cy >>> step;
    dy = cx >>> step;
    z_neg = cz[33];
    x_fin = flip ? -cx : cx;
    y_fin = flip ? -cy : cy;
  end

  // shared multiplier with rounding
  logic signed [31:0] ma, mb;
  logic signed [63:0] mprod;
  logic signed [31:0] mres;
  always_comb begin
    ma = '0; mb = '0;
    case (mstep)
      4'd0: begin ma = cp; mb = cw; end
      4'd1: begin ma = cp; mb = sw; end
      4'd2: begin ma = sr; mb = sp; end
      4'd3: begin ma = cr; mb = sp; end
      4'd4: begin ma = cr; mb = sw; end
      4'd5: begin ma = tsp; mb = cw; end
      4'd6: begin ma = cr; mb = cw; end
      4'd7: begin ma = tsp; mb = sw; end
      4'd8: begin ma = sr; mb = cp; end
      4'd9: begin ma = sr; mb = sw; end
      4'd10: begin ma = tcp; mb = cw; end
      4'd11: begin ma = sr; mb = cw; end
      4'd12: begin ma = tcp; mb = sw; end
      4'd13: begin ma = cr; mb = cp; end
      default: ;
    endcase
    mprod = ma * mb + 64'sd536870912;
    mres = 32'(mprod >>> 30);
  end

  logic cordic_done;
  assign cordic_done = (step == 5'(erpt_pkg::CORDIC_STEPS));
  assign busy = (state != erpt_pkg::MB_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      erpt_pkg::MB_IDLE:  if (start) state_next = erpt_pkg::MB_ROLL;
      erpt_pkg::MB_ROLL:  if (cordic_done) state_next = erpt_pkg::MB_PITCH;
      erpt_pkg::MB_PITCH: if (cordic_done) state_next = erpt_pkg::MB_YAW;
      erpt_pkg::MB_YAW:   if (cordic_done) state_next = erpt_pkg::MB_MUL1;
      erpt_pkg::MB_MUL1:  if (mstep == 4'd13) state_next = erpt_pkg::MB_IDLE;
      default:            state_next = erpt_pkg::MB_IDLE;
    endcase
    if (start) state_next = erpt_pkg::MB_ROLL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erpt_pkg::MB_ROLL;
      step <= 5'd31;
      mstep <= '0;
    end else begin
      state <= state_next;
      if (start || (cordic_done && state != erpt_pkg::MB_MUL1)) step <= 5'd31;
      else if (step == 5'd31) step <= '0;
      else if (!cordic_done) step <= step + 5'd1;
      if (state != erpt_pkg::MB_MUL1 || start) mstep <= '0;
      else mstep <= mstep + 4'd1;
    end
  end

  // step 31 marks the load cycle with quadrant folding
  always_ff @(posedge clk) begin
    if (step == 5'd31) begin
      cx <= erpt_pkg::CORDIC_GAIN;
      cy <= '0;
      if (z0 > 34'sd1073741824) begin
        cz <= z0 - 34'sd2147483648; flip <= 1'b1;
      end else if (z0 < -34'sd1073741824) begin
        cz <= z0 + 34'sd2147483648; flip <= 1'b1;
      end else begin
        cz <= z0; flip <= 1'b0;
      end
    end else if (!cordic_done) begin
      if (!z_neg) begin
        cx <= cx - dx; cy <= cy + dy; cz <= cz - erpt_pkg::atan_turn(step);
      end else begin
        cx <= cx + dx; cy <= cy - dy; cz <= cz + erpt_pkg::atan_turn(step);
      end
    end
    if (cordic_done) begin
      case (state)
        erpt_pkg::MB_ROLL:  begin cr <= 32'(x_fin); sr <= 32'(y_fin); end
        erpt_pkg::MB_PITCH: begin cp <= 32'(x_fin); sp <= 32'(y_fin); end
        erpt_pkg::MB_YAW:   begin cw <= 32'(x_fin); sw <= 32'(y_fin); end
        default: ;
      endcase
    end
    if (state == erpt_pkg::MB_MUL1) begin
      case (mstep)
        4'd0: begin coef[0] <= mres; coef[2] <= -sp; end
        4'd1: coef[1] <= mres;
        4'd2: tsp <= mres;
        4'd3: tcp <= mres;
        4'd4: coef[3] <= -mres;
        4'd5: coef[3] <= coef[3] + mres;
        4'd6: coef[4] <= mres;
        4'd7: coef[4] <= coef[4] + mres;
        4'd8: coef[5] <= mres;
        4'd9: coef[6] <= mres;
        4'd10: coef[6] <= coef[6] + mres;
        4'd11: coef[7] <= -mres;
        4'd12: coef[7] <= coef[7] + mres;
        4'd13: coef[8] <= mres;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    start |=> state == erpt_pkg::MB_ROLL) else $error("rebuild did not restart");
  assert property (@(posedge clk) disable iff (rst)
    state == erpt_pkg::MB_MUL1 |-> mstep <= 4'd13) else $error("product step overrun");
  assert property (@(posedge clk) disable iff (rst)
    step != 5'd31 |-> step <= 5'(erpt_pkg::CORDIC_STEPS)) else $error("cordic step overrun");
endmodule
`default_nettype wire

// File: rtl/euler_rigid_point_transform.sv
// Top level: configuration registers, coefficient builder, 4-stage point pipeline.
// Depends on erpt_pkg, erpt_if, erpt_matrix.
//
//  channel  dir  beat payload
//  pt_in    in   point_x, point_y, point_z, landmark_tag
//  pt_out   out  moved_x, moved_y, moved_z, moved_tag
//  cfg      in   cfg_we, cfg_index, cfg_data (no handshake)
//
// One point per cycle while neither stalled nor rebuilding; four register stages
// (subtract, multiply, sum, saturate) lie between the input and the output.
// After reset or an angle write the builder runs a load, 28 CORDIC steps and a
// capture for each angle, then its 14 product steps; no point is accepted
// meanwhile, nor in the cycle between an angle write and the builder start.
// Reset is synchronous; the pipeline advances whenever the output stage is
// free or being drained, so a stall holds every stage.
`default_nettype none
module euler_rigid_point_transform #(
  parameter int POSITION_FRACTION_BITS = erpt_pkg::DEF_POSITION_FRACTION_BITS,
  parameter int ANGLE_WIDTH = erpt_pkg::DEF_ANGLE_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  erpt_point_if.sink pt_in,
  erpt_moved_if.source pt_out,
  input wire logic cfg_we,
  input wire logic [erpt_pkg::IDX_W-1:0] cfg_index,
  input wire logic [erpt_pkg::CFG_W-1:0] cfg_data
);
  // Q format does not scale the transform, but at zero or less pt_in.ready stays low
  localparam int FRAC_UNUSED = POSITION_FRACTION_BITS;

  logic signed [ANGLE_WIDTH-1:0] roll, pitch, yaw;
  logic signed [31:0] sx, sy, sz;
  logic rebuild, busy;
  logic signed [31:0] coef [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      roll <= '0; pitch <= '0; yaw <= '0; sx <= '0; sy <= '0; sz <= '0;
      rebuild <= 1'b0;
    end else begin
      rebuild <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          erpt_pkg::REG_ROLL:  begin roll <= cfg_data[ANGLE_WIDTH-1:0]; rebuild <= 1'b1; end
          erpt_pkg::REG_PITCH: begin pitch <= cfg_data[ANGLE_WIDTH-1:0]; rebuild <= 1'b1; end
          erpt_pkg::REG_YAW:   begin yaw <= cfg_data[ANGLE_WIDTH-1:0]; rebuild <= 1'b1; end
          erpt_pkg::REG_SX:    sx <= cfg_data;
          erpt_pkg::REG_SY:    sy <= cfg_data;
          erpt_pkg::REG_SZ:    sz <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  erpt_matrix #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_matrix (
    .clk(clk), .rst(rst), .start(rebuild),
    .roll(roll), .pitch(pitch), .yaw(yaw), .busy(busy), .coef(coef)
  );

  logic v1, v2, v3, v4, adv;
  logic signed [32:0] d [3];
  logic signed [63:0] prod [9];
  logic signed [34:0] acc [3];
  logic [erpt_pkg::TAG_W-1:0] t1, t2, t3;

  function automatic logic signed [31:0] sat(input logic signed [34:0] a);
    if (a > 35'sd2147483647) sat = 32'h7FFFFFFF;
    else if (a < -35'sd2147483648) sat = 32'h80000000;
    else sat = 32'(a);
  endfunction

  assign adv = !v4 || pt_out.ready;
  assign pt_in.ready = adv && !busy && !rebuild && (FRAC_UNUSED > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v1 <= pt_in.valid && pt_in.ready;
      v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[0] <= 33'(pt_in.point_x) - 33'(sx);
      d[1] <= 33'(pt_in.point_y) - 33'(sy);
      d[2] <= 33'(pt_in.point_z) - 33'(sz);
      t1 <= pt_in.landmark_tag;
      for (int k = 0; k < 9; k++)
        prod[k] <= ((64'(coef[k]) * 64'(d[k%3])) + 64'sd536870912) >>> 30;
      t2 <= t1;
      for (int r = 0; r < 3; r++)
        acc[r] <= 35'(prod[3*r]) + 35'(prod[3*r+1]) + 35'(prod[3*r+2]);
      t3 <= t2;
      pt_out.moved_x <= sat(acc[0]);
      pt_out.moved_y <= sat(acc[1]);
      pt_out.moved_z <= sat(acc[2]);
      pt_out.moved_tag <= t3;
    end
  end

  assign pt_out.valid = v4;

  assert property (@(posedge clk) disable iff (rst)
    busy |-> !pt_in.ready) else $error("point taken during rebuild");
  assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && !pt_out.ready |=> pt_out.valid && $stable(pt_out.moved_tag))
    else $error("stalled result lost");
  assert property (@(posedge clk) disable iff (rst)
    v3 && !adv |=> v3) else $error("stall dropped stage three");
endmodule
`default_nettype wire

// File: bench/erpt_transform_checker.sv
// Watches the point and result channels and the register port of the transform,
// predicts each moved point and compares it. Depends on erpt_pkg and erpt_if.
`timescale 1ns / 1ps
module erpt_transform_checker (
  input logic clk,
  input logic rst,
  erpt_point_if pin,
  erpt_moved_if pout,
  input logic cfg_we,
  input logic [erpt_pkg::IDX_W-1:0] cfg_index,
  input logic [erpt_pkg::CFG_W-1:0] cfg_data,
  output int errors,
  output int pending,
  output int n_checked,
  output int n_saturated
);
  import erpt_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [TAG_W-1:0] tag;
  } moved_pt_t;

  localparam longint ROT_GAIN = 652032874;
  localparam longint QTURN = 64'sd1073741824;
  localparam longint HTURN = 64'sd2147483648;
  localparam longint ATAN_STEP [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

  logic [15:0] angle_r [3];
  logic signed [POS_W-1:0] shift_r [3];
  longint rot [3][3];
  moved_pt_t moved_q[$];

  function automatic longint rmul(input longint a, input longint b);
    rmul = (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic angle_to_trig(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed({ang, 16'h0000}));
    flip = 0;
    x = ROT_GAIN;
    y = 0;
    if (z > QTURN) begin
      z -= HTURN; flip = 1;
    end else if (z < -QTURN) begin
      z += HTURN; flip = 1;
    end
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic rebuild_rotation();
    longint cr, sr, cp, sp, cy, sy;
    angle_to_trig(angle_r[0], cr, sr);
    angle_to_trig(angle_r[1], cp, sp);
    angle_to_trig(angle_r[2], cy, sy);
    rot[0][0] = rmul(cp, cy);
    rot[0][1] = rmul(cp, sy);
    rot[0][2] = -sp;
    rot[1][0] = -rmul(cr, sy) + rmul(rmul(sr, sp), cy);
    rot[1][1] = rmul(cr, cy) + rmul(rmul(sr, sp), sy);
    rot[1][2] = rmul(sr, cp);
    rot[2][0] = rmul(sr, sy) + rmul(rmul(cr, sp), cy);
    rot[2][1] = -rmul(sr, cy) + rmul(rmul(cr, sp), sy);
    rot[2][2] = rmul(cr, cp);
  endtask

  function automatic moved_pt_t transform_point(input logic signed [POS_W-1:0] px,
      input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] pz,
      input logic [TAG_W-1:0] tag);
    longint d [3];
    longint acc;
    logic signed [POS_W-1:0] res [3];
    d[0] = longint'(px) - longint'(shift_r[0]);
    d[1] = longint'(py) - longint'(shift_r[1]);
    d[2] = longint'(pz) - longint'(shift_r[2]);
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rmul(rot[r][j], d[j]);
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647; n_saturated++;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648; n_saturated++;
      end
      res[r] = acc[31:0];
    end
    transform_point = '{res[0], res[1], res[2], tag};
  endfunction

  always @(posedge clk) begin
    moved_pt_t want;
    if (rst) begin
      foreach (angle_r[i]) angle_r[i] = '0;
      foreach (shift_r[i]) shift_r[i] = '0;
      rebuild_rotation();
      moved_q.delete();
      errors = 0;
      n_checked = 0;
      n_saturated = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROLL, REG_PITCH, REG_YAW: begin
            angle_r[cfg_index[1:0]] = cfg_data[15:0];
            rebuild_rotation();
          end
          REG_SX, REG_SY, REG_SZ: shift_r[2'(cfg_index - REG_SX)] = cfg_data;
          default: ;
        endcase
      end
      if (pin.valid && pin.ready)
        moved_q.insert(moved_q.size(), transform_point(pin.point_x, pin.point_y,
                                                       pin.point_z, pin.landmark_tag));
      if (pout.valid && pout.ready) begin
        if (moved_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat tag %h", pout.moved_tag);
        end else begin
          want = moved_q.pop_front();
          n_checked++;
          if (pout.moved_x !== want.x || pout.moved_y !== want.y ||
              pout.moved_z !== want.z || pout.moved_tag !== want.tag) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: want x=%0d y=%0d z=%0d tag=%h, got x=%0d y=%0d z=%0d tag=%h",
                       want.x, want.y, want.z, want.tag,
                       pout.moved_x, pout.moved_y, pout.moved_z, pout.moved_tag);
          end
        end
      end
    end
    pending = moved_q.size();
  end
endmodule

// File: bench/euler_rigid_point_transform_test.sv
// Top of the transform bench: clock, reset, point stimulus, register writes and verdict.
// Depends on erpt_pkg, erpt_if, the block and erpt_transform_checker.
`timescale 1ns / 1ps
module euler_rigid_point_transform_test;
  import erpt_pkg::*;

  logic clk, rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int errors, pending, n_checked, n_saturated;
  int send_idle, recv_idle, stall_left, quiet_cycles, n_writes;
  bit stall_req;

  erpt_point_if pin ();
  erpt_moved_if pout ();

  euler_rigid_point_transform dut (
    .clk(clk), .rst(rst), .pt_in(pin), .pt_out(pout),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  erpt_transform_checker chk (
    .clk(clk), .rst(rst), .pin(pin), .pout(pout),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .n_checked(n_checked), .n_saturated(n_saturated)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random idling plus one long hold-off on request
  initial begin
    pout.ready = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pout.ready = 0;
      end else if (stall_req) begin
        stall_req = 0;
        stall_left = 300;
        pout.ready = 0;
      end else
        pout.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on beats and register writes
  always @(posedge clk) begin
    if ((pin.valid && pin.ready) || (pout.valid && pout.ready) || cfg_we || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= 20000) begin
      $display("Mismatches found");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [15:0] tag);
    while ($urandom_range(99) < send_idle) begin
      pin.valid = 0;
      @(negedge clk);
    end
    pin.valid = 1;
    pin.point_x = px;
    pin.point_y = py;
    pin.point_z = pz;
    pin.landmark_tag = tag;
    do @(posedge clk); while (!pin.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    n_writes++;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // block must be drained before registers change
  task automatic drain();
    pin.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: rand_pos = $urandom;
      1: rand_pos = $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
                                      : 32'h80000000 + $urandom_range(255);
      default: rand_pos = 32'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  initial begin
    logic [31:0] sx, sy, sz;
    rst = 1;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    pin.valid = 0; pin.point_x = '0; pin.point_y = '0; pin.point_z = '0;
    pin.landmark_tag = '0;
    send_idle = 0; recv_idle = 0; stall_req = 0; n_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // identity rotation, zero shift: extremes pass straight through
    send_point(32'h7fffffff, 32'h80000000, 32'h0, 16'h0000);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 16'hffff);
    send_point(32'h1, 32'h0, 32'h7fffffff, 16'h5a5a);
    send_point(32'h00010000, 32'hffff0000, 32'h80000000, 16'ha5a5);
    drain();
    write_reg(REG_ROLL, 32'h00004000);
    write_reg(REG_PITCH, 32'hffffc000);
    write_reg(REG_YAW, 32'h00007fff);
    write_reg(REG_SX, 32'h80000000);
    write_reg(REG_SY, 32'h7fffffff);
    write_reg(REG_SZ, 32'h80000000);
    write_reg(3'd6, 32'hffffffff);  // out of range, ignored
    write_reg(3'd7, 32'h12345678);
    // far-off points against extreme shifts saturate
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h0001);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h8000);
    send_point(32'h0, 32'h0, 32'h0, 16'h7fff);
    send_point(32'hffffffff, 32'h1, 32'hffffffff, 16'hfffe);
    drain();
    write_reg(REG_ROLL, 32'hffff8000);
    write_reg(REG_PITCH, 32'h00007fff);
    write_reg(REG_YAW, 32'h00008000);
    write_reg(REG_SX, 32'h7fffffff);
    write_reg(REG_SY, 32'h80000000);
    write_reg(REG_SZ, 32'h0);
    send_point(32'h80000000, 32'h7fffffff, 32'h0, 16'h0f0f);
    send_point(32'h7fffffff, 32'h80000000, 32'h12345678, 16'hf0f0);
    send_point(32'h00008000, 32'hffff8000, 32'h0, 16'h0);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      send_idle = (ph < 4) ? 31 : (ph < 8) ? 79 : 0;
      recv_idle = (ph < 4) ? 79 : (ph < 8) ? 31 : 0;
      case (ph % 4)
        0: begin
          sx = $urandom; sy = $urandom; sz = $urandom;
        end
        1: begin
          sx = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
          sy = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
          sz = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        end
        2: begin
          sx = 0; sy = 0; sz = 0;
        end
        default: begin
          sx = rand_pos(); sy = rand_pos(); sz = rand_pos();
        end
      endcase
      for (int a = 0; a < 3; a++)
        write_reg(a[IDX_W-1:0], (ph % 4 == 1) ? ($urandom_range(1) ? 32'h7fff : 32'hffff8000)
                                 : (ph % 4 == 2) ? $urandom_range(255) : $urandom);
      write_reg(REG_SX, sx);
      write_reg(REG_SY, sy);
      write_reg(REG_SZ, sz);
      if (ph == 8) stall_req = 1;  // block fills up and backs up the input
      for (int k = 0; k < 80; k++)
        send_point(rand_pos(), rand_pos(), rand_pos(), 16'($urandom));
    end
    pin.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Checked %0d moved points over %0d register writes, %0d saturated coordinates.",
             n_checked, n_writes, n_saturated);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// File: filelist.f
rtl/erpt_pkg.sv
rtl/erpt_if.sv
rtl/erpt_matrix.sv
rtl/euler_rigid_point_transform.sv
bench/erpt_transform_checker.sv
bench/euler_rigid_point_transform_test.sv
